// File: design/ptu_pkg.sv
// Shared types, field layout and codes of the palettized texture unswizzle core.
package ptu_pkg;

    // Defaults of the top-level parameters
    localparam int TEX_ADDR_BITS_DEF = 18;
    localparam int MAX_LOG2_DIM_DEF  = 10;

    // Fixed field widths
    localparam int KIND_W        = 2;
    localparam int TEX_ADDR_W    = 18;
    localparam int PAL_INDEX_W   = 8;
    localparam int WRITE_VALUE_W = 32;
    localparam int PIXEL_W       = 10;
    localparam int COLOR_W       = 32;
    localparam int TEXEL_W       = 8;
    localparam int NIBBLE_W      = 4;

    // Slave tdata layout, lowest field first, padded to whole bytes
    localparam int TEX_ADDR_LSB    = 0;
    localparam int PAL_INDEX_LSB   = TEX_ADDR_LSB + TEX_ADDR_W;
    localparam int WRITE_VALUE_LSB = PAL_INDEX_LSB + PAL_INDEX_W;
    localparam int PIXEL_X_LSB     = WRITE_VALUE_LSB + WRITE_VALUE_W;
    localparam int PIXEL_Y_LSB     = PIXEL_X_LSB + PIXEL_W;
    localparam int S_FIELDS_W      = PIXEL_Y_LSB + PIXEL_W;
    localparam int S_TDATA_W       = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W       = COLOR_W;

    // Word kinds on tuser
    localparam logic [KIND_W-1:0] KIND_TEX_WR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAL_WR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    // Configuration registers
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 2;
    localparam int MODE_W     = 2;
    localparam int LOG2_W     = 4;

    localparam logic [REG_IDX_W-1:0] REG_MODE        = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOG2_WIDTH  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOG2_HEIGHT = 2'd2;

    localparam logic [MODE_W-1:0] MODE_LIN8 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LIN4 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SWZ8 = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SWZ4 = 2'd3;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_LIN8;
    localparam logic [LOG2_W-1:0] LOG2_RESET = 4'd7;

    // Swizzled 4-bit page is 128 pixels on a side
    localparam int PAGE_LOG2 = 7;

    localparam int PAL_DEPTH = 256;
    localparam int OUT_DEPTH = 8;

    // Per-word control that travels down the pipeline
    typedef struct packed {
        logic tex_wr;
        logic pal_wr;
        logic query;
        logic nib_en;
        logic nib_hi;
    } ctrl_t;

endpackage

// File: design/ptu_ram.sv
// Generic single-port RAM with registered read data.
module ptu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/ptu_addr_gen.sv
// Texel address terms for linear and swizzled layouts, plus per-word control.
module ptu_addr_gen #(
    parameter int TEX_ADDR_BITS = ptu_pkg::TEX_ADDR_BITS_DEF,
    parameter int MAX_LOG2_DIM  = ptu_pkg::MAX_LOG2_DIM_DEF
) (
    input  logic [ptu_pkg::MODE_W-1:0]     mode,
    input  logic [ptu_pkg::LOG2_W-1:0]     log2_width,
    input  logic [ptu_pkg::LOG2_W-1:0]     log2_height,
    input  logic [ptu_pkg::KIND_W-1:0]     kind,
    input  logic [ptu_pkg::TEX_ADDR_W-1:0] tex_addr,
    input  logic [ptu_pkg::PIXEL_W-1:0]    pixel_x,
    input  logic [ptu_pkg::PIXEL_W-1:0]    pixel_y,
    output ptu_pkg::ctrl_t                 ctrl,
    output logic [TEX_ADDR_BITS-1:0]       term0,
    output logic [TEX_ADDR_BITS-1:0]       term1,
    output logic [TEX_ADDR_BITS-1:0]       term2
);

    import ptu_pkg::*;

    localparam int DIM_W = MAX_LOG2_DIM;
    localparam int L_W   = $clog2(MAX_LOG2_DIM + 2);
    localparam int SH_W  = $clog2(MAX_LOG2_DIM + 8);
    localparam int PN_W  = DIM_W + 1;
    localparam int LIN_W = TEX_ADDR_BITS + 1;
    localparam int A_W   = TEX_ADDR_BITS;

    localparam logic [LOG2_W-1:0] MAX_L  = LOG2_W'(MAX_LOG2_DIM);
    localparam logic [L_W-1:0]    PAGE_L = L_W'(PAGE_LOG2);

    logic [LOG2_W-1:0] lw_clamp;
    logic [LOG2_W-1:0] lh_clamp;
    logic [L_W-1:0]    lw;
    logic [L_W-1:0]    lh;
    logic [L_W-1:0]    lh_eff;
    logic [L_W-1:0]    lph;
    logic [L_W-1:0]    lpv;
    logic [DIM_W-1:0]  x;
    logic [DIM_W-1:0]  y;
    logic [LIN_W-1:0]  lin;
    logic [2:0]        y_plus2;
    logic [2:0]        colx;
    logic [2:0]        pos_y;
    logic [PN_W-1:0]   page_num;
    logic [PN_W-1:0]   pn_hi;
    logic [PN_W-1:0]   pn_low;
    logic [SH_W-1:0]   sh_lw1;
    logic [SH_W-1:0]   sh_lh1;
    logic [SH_W-1:0]   sh_lh4;
    logic [SH_W-1:0]   sh_lh6;

    // Clamp dimensions and wrap coordinates into the texture
    always_comb
    begin
        lw_clamp = (log2_width > MAX_L) ? MAX_L : log2_width;
        lh_clamp = (log2_height > MAX_L) ? MAX_L : log2_height;
        lw       = L_W'(lw_clamp);
        lh       = L_W'(lh_clamp);
        x        = DIM_W'(pixel_x) & ~({DIM_W{1'b1}} << lw);
        y        = DIM_W'(pixel_y) & ~({DIM_W{1'b1}} << lh);
        lin      = (LIN_W'(y) << lw) + LIN_W'(x);
    end

    // Column position shared by both swizzled layouts
    always_comb
    begin
        y_plus2 = y[2:0] + 3'd2;
        colx    = x[2:0] + {y_plus2[2], 2'b00};
        pos_y   = {y[3], y[2], y[0]};
    end

    // Page geometry of the 4-bit swizzle; non-square textures double height
    always_comb
    begin
        lh_eff   = (lw != lh) ? lh + L_W'(1) : lh;
        lph      = (lw >= PAGE_L) ? lw - PAGE_L : '0;
        lpv      = (lh_eff >= PAGE_L) ? lh_eff - PAGE_L : '0;
        page_num = (PN_W'(y >> PAGE_LOG2) << lph) + PN_W'(x >> PAGE_LOG2);
        pn_hi    = page_num >> lpv;
        pn_low   = page_num & ~({PN_W{1'b1}} << lpv);
        sh_lw1   = SH_W'(lw) + SH_W'(1);
        sh_lh1   = SH_W'(lh_eff) + SH_W'(1);
        sh_lh4   = SH_W'(lh_eff) + SH_W'(4);
        sh_lh6   = SH_W'(lh_eff) + SH_W'(6);
    end

    // Select the address terms; each term holds disjoint bit fields
    always_comb
    begin
        term0 = '0;
        term1 = '0;
        term2 = '0;
        if (kind == KIND_TEX_WR)
        begin
            term0 = A_W'(tex_addr);
        end
        else
        begin
            case (mode)
                MODE_LIN8:
                begin
                    term0 = A_W'(lin);
                end
                MODE_LIN4:
                begin
                    term0 = A_W'(lin >> 1);
                end
                MODE_SWZ8:
                begin
                    term0 = A_W'(y & ~DIM_W'(4'hf)) << lw;
                    term1 = A_W'(pos_y) << sh_lw1;
                    term2 = A_W'({x & ~DIM_W'(4'hf), 1'b0})
                          | A_W'({colx, x[3], y[1]});
                end
                MODE_SWZ4:
                begin
                    term0 = A_W'(pn_hi) << sh_lh6;
                    term1 = (A_W'(x[6:5]) << sh_lh4) | (A_W'(pos_y) << sh_lh1);
                    term2 = (A_W'(pn_low) << 8)
                          | A_W'({y[6:4], colx, x[4:3]});
                end
                default:
                begin
                    term0 = '0;
                end
            endcase
        end
    end

    // Word control and nibble choice
    always_comb
    begin
        ctrl.tex_wr = (kind == KIND_TEX_WR);
        ctrl.pal_wr = (kind == KIND_PAL_WR);
        ctrl.query  = (kind == KIND_QUERY);
        ctrl.nib_en = (mode == MODE_LIN4) || (mode == MODE_SWZ4);
        ctrl.nib_hi = (mode == MODE_LIN4) ? lin[0] : y[1];
    end

endmodule

// File: design/ptu_out_queue.sv
// Result queue between the palette read and the master stream side.
module ptu_out_queue #(
    parameter int WIDTH = ptu_pkg::COLOR_W,
    parameter int DEPTH = ptu_pkg::OUT_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop_ready,
    output logic                       out_valid,
    output logic [WIDTH-1:0]           out_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] buf_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    assign pop = out_valid && pop_ready;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = buf_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// File: design/palettized_texture_unswizzle_core.sv
// Top level: palettized texture fetch with linear and swizzled layouts.
//
// Takes one word per clock of any kind while s_tready is high: texture byte
// writes, palette writes and pixel queries. A query returns its palette color
// through an address stage, a texture RAM read and a palette RAM read, each
// one register deep, and then an eight-word result queue. Input stays ready
// as long as the queue has room for every query in flight, so with the output
// side ready the block sustains one query per clock. Writes and queries reach
// each RAM in arrival order, so a query sees every write accepted before it.
// Both RAMs come out of reset with no defined contents and need no clearing
// pass: load them before querying.
module palettized_texture_unswizzle_core #(
    parameter int TEX_ADDR_BITS = ptu_pkg::TEX_ADDR_BITS_DEF,
    parameter int MAX_LOG2_DIM  = ptu_pkg::MAX_LOG2_DIM_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Slave stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tex_addr[17:0], pal_index[25:18], write_value[57:26],
    // pixel_x[67:58], pixel_y[77:68], zero pad [79:78]
    input  logic [ptu_pkg::S_TDATA_W-1:0] s_tdata,
    // kind[1:0]
    input  logic [ptu_pkg::KIND_W-1:0]    s_tuser,
    // Master stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // color[31:0]
    output logic [ptu_pkg::M_TDATA_W-1:0] m_tdata,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptu_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ptu_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ptu_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready
);

    import ptu_pkg::*;

    localparam int A_W    = TEX_ADDR_BITS;
    localparam int Q_CNT  = $clog2(OUT_DEPTH + 1);
    localparam int SUM_W  = Q_CNT + 1;
    localparam int PAL_AW = $clog2(PAL_DEPTH);

    // Configuration registers
    logic [MODE_W-1:0] mode_reg;
    logic [LOG2_W-1:0] log2_width_reg;
    logic [LOG2_W-1:0] log2_height_reg;
    logic              cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    // Input unpack
    logic                     in_accept;
    logic [TEX_ADDR_W-1:0]    in_tex_addr;
    logic [PAL_INDEX_W-1:0]   in_pal_index;
    logic [WRITE_VALUE_W-1:0] in_write_value;
    logic [PIXEL_W-1:0]       in_pixel_x;
    logic [PIXEL_W-1:0]       in_pixel_y;

    // Address stage
    ctrl_t                    gen_ctrl;
    logic [A_W-1:0]           gen_term0;
    logic [A_W-1:0]           gen_term1;
    logic [A_W-1:0]           gen_term2;
    ctrl_t                    s1_ctrl_reg;
    ctrl_t                    s1_ctrl_next;
    logic [A_W-1:0]           s1_term0_reg;
    logic [A_W-1:0]           s1_term1_reg;
    logic [A_W-1:0]           s1_term2_reg;
    logic [WRITE_VALUE_W-1:0] s1_wdata_reg;
    logic [PAL_INDEX_W-1:0]   s1_pal_index_reg;

    // Texture read stage
    logic [A_W-1:0]           tex_addr;
    logic                     tex_en;
    logic [TEXEL_W-1:0]       tex_rdata;
    ctrl_t                    s2_ctrl_reg;
    logic [WRITE_VALUE_W-1:0] s2_wdata_reg;
    logic [PAL_INDEX_W-1:0]   s2_pal_index_reg;

    // Palette read stage
    logic [PAL_INDEX_W-1:0]   texel_idx;
    logic [PAL_AW-1:0]        pal_addr;
    logic                     pal_en;
    logic [COLOR_W-1:0]       pal_rdata;
    logic                     s3_query_reg;

    // Result queue
    logic [Q_CNT-1:0]         q_count;
    logic [1:0]               inflight;
    logic [SUM_W-1:0]         occupancy;

    // Register file writes and reads
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_RESET;
            log2_width_reg  <= LOG2_RESET;
            log2_height_reg <= LOG2_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MODE:        mode_reg        <= pwdata[MODE_W-1:0];
                REG_LOG2_WIDTH:  log2_width_reg  <= pwdata[LOG2_W-1:0];
                REG_LOG2_HEIGHT: log2_height_reg <= pwdata[LOG2_W-1:0];
                default:         mode_reg        <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_MODE:        prdata = CFG_DATA_W'(mode_reg);
            REG_LOG2_WIDTH:  prdata = CFG_DATA_W'(log2_width_reg);
            REG_LOG2_HEIGHT: prdata = CFG_DATA_W'(log2_height_reg);
            default:         prdata = '0;
        endcase
    end

    // Unpack the input word
    assign in_accept      = s_tvalid && s_tready;
    assign in_tex_addr    = s_tdata[TEX_ADDR_LSB +: TEX_ADDR_W];
    assign in_pal_index   = s_tdata[PAL_INDEX_LSB +: PAL_INDEX_W];
    assign in_write_value = s_tdata[WRITE_VALUE_LSB +: WRITE_VALUE_W];
    assign in_pixel_x     = s_tdata[PIXEL_X_LSB +: PIXEL_W];
    assign in_pixel_y     = s_tdata[PIXEL_Y_LSB +: PIXEL_W];

    ptu_addr_gen #(
        .TEX_ADDR_BITS (TEX_ADDR_BITS),
        .MAX_LOG2_DIM  (MAX_LOG2_DIM)
    ) u_addr_gen (
        .mode        (mode_reg),
        .log2_width  (log2_width_reg),
        .log2_height (log2_height_reg),
        .kind        (s_tuser),
        .tex_addr    (in_tex_addr),
        .pixel_x     (in_pixel_x),
        .pixel_y     (in_pixel_y),
        .ctrl        (gen_ctrl),
        .term0       (gen_term0),
        .term1       (gen_term1),
        .term2       (gen_term2)
    );

    // Hold queue room for every query in flight
    assign inflight  = 2'(s1_ctrl_reg.query) + 2'(s2_ctrl_reg.query) + 2'(s3_query_reg);
    assign occupancy = SUM_W'(q_count) + SUM_W'(inflight);
    assign s_tready  = (occupancy < SUM_W'(OUT_DEPTH));

    // Pipeline control, cleared on reset
    assign s1_ctrl_next = in_accept ? gen_ctrl : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg  <= '0;
            s2_ctrl_reg  <= '0;
            s3_query_reg <= 1'b0;
        end
        else
        begin
            s1_ctrl_reg  <= s1_ctrl_next;
            s2_ctrl_reg  <= s1_ctrl_reg;
            s3_query_reg <= s2_ctrl_reg.query;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        s1_term0_reg     <= gen_term0;
        s1_term1_reg     <= gen_term1;
        s1_term2_reg     <= gen_term2;
        s1_wdata_reg     <= in_write_value;
        s1_pal_index_reg <= in_pal_index;
        s2_wdata_reg     <= s1_wdata_reg;
        s2_pal_index_reg <= s1_pal_index_reg;
    end

    // Sum the address terms and access the texture store in order
    assign tex_addr = s1_term0_reg + s1_term1_reg + s1_term2_reg;
    assign tex_en   = s1_ctrl_reg.tex_wr || s1_ctrl_reg.query;

    ptu_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (2 ** TEX_ADDR_BITS)
    ) u_tex_ram (
        .clk   (clk),
        .en    (tex_en),
        .we    (s1_ctrl_reg.tex_wr),
        .addr  (tex_addr),
        .wdata (s1_wdata_reg[TEXEL_W-1:0]),
        .rdata (tex_rdata)
    );

    // Pick the texel nibble and access the palette in order
    always_comb
    begin
        if (!s2_ctrl_reg.nib_en)
        begin
            texel_idx = tex_rdata;
        end
        else if (s2_ctrl_reg.nib_hi)
        begin
            texel_idx = PAL_INDEX_W'(tex_rdata[TEXEL_W-1:NIBBLE_W]);
        end
        else
        begin
            texel_idx = PAL_INDEX_W'(tex_rdata[NIBBLE_W-1:0]);
        end
    end

    assign pal_addr = s2_ctrl_reg.pal_wr ? s2_pal_index_reg : texel_idx;
    assign pal_en   = s2_ctrl_reg.pal_wr || s2_ctrl_reg.query;

    ptu_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PAL_DEPTH)
    ) u_pal_ram (
        .clk   (clk),
        .en    (pal_en),
        .we    (s2_ctrl_reg.pal_wr),
        .addr  (pal_addr),
        .wdata (s2_wdata_reg),
        .rdata (pal_rdata)
    );

    ptu_out_queue #(
        .WIDTH (COLOR_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_query_reg),
        .push_data (pal_rdata),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .count     (q_count)
    );

`ifndef ASSERT_OFF
    // Queue plus queries in flight never exceed the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= SUM_W'(OUT_DEPTH))
        else $error("result queue over-committed");

    // An accepted query enters the address stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_tuser == KIND_QUERY) |=> s1_ctrl_reg.query)
        else $error("accepted query lost before address stage");

    // Output becomes valid only after a palette read completes
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s3_query_reg))
        else $error("result appeared without a palette read");
`endif

endmodule

// File: tb/ptu_checker.sv
// Checker for the palettized texture unswizzle core: texel address helper and result scoreboard.
package ptu_tb_pkg;

    import ptu_pkg::*;

    // Kind code the block must ignore
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    // Register index with no register behind it
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Where a pixel's texel sits in the texture store
    typedef struct packed {
        logic [TEX_ADDR_W-1:0] addr;
        logic                  nibble;
        logic                  upper;
    } texel_loc_t;

    // Map a queried pixel to its texel byte address and nibble select
    function automatic texel_loc_t texel_locate(input logic [MODE_W-1:0]  mode,
                                                input logic [LOG2_W-1:0]  lw_reg,
                                                input logic [LOG2_W-1:0]  lh_reg,
                                                input logic [PIXEL_W-1:0] px,
                                                input logic [PIXEL_W-1:0] py);
        texel_loc_t  loc;
        int unsigned lw;
        int unsigned lh;
        int unsigned lh_eff;
        int unsigned lph;
        int unsigned lpv;
        logic [63:0] w;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] lin;
        logic [63:0] height;
        logic [63:0] page_num;
        logic [63:0] page;
        logic [63:0] blk;
        logic [63:0] col;
        logic [63:0] swap;
        logic [63:0] pos_y;
        logic [63:0] byte_sel;
        logic [63:0] base;

        // Clamp oversized dimensions and wrap the coordinates
        lw = (lw_reg > MAX_LOG2_DIM_DEF) ? MAX_LOG2_DIM_DEF : lw_reg;
        lh = (lh_reg > MAX_LOG2_DIM_DEF) ? MAX_LOG2_DIM_DEF : lh_reg;
        w = 64'd1 << lw;
        x = {54'd0, px} & (w - 64'd1);
        y = {54'd0, py} & ((64'd1 << lh) - 64'd1);
        lin = (y << lw) + x;

        loc.nibble = 1'b0;
        loc.upper  = 1'b0;
        swap  = (((y + 64'd2) >> 2) & 64'd1) * 64'd4;
        pos_y = (((y & ~64'd3) >> 1) + (y & 64'd1)) & 64'h7;

        case (mode)
            MODE_LIN8: base = lin;
            MODE_LIN4:
            begin
                base       = lin >> 1;
                loc.nibble = 1'b1;
                loc.upper  = lin[0];
            end
            MODE_SWZ8:
            begin
                blk      = (y & ~64'hf) * w + (x & ~64'hf) * 64'd2;
                col      = pos_y * w * 64'd2 + ((x + swap) & 64'h7) * 64'd4;
                byte_sel = ((y >> 1) & 64'd1) + ((x >> 2) & 64'd2);
                base     = blk + col + byte_sel;
            end
            default:
            begin
                // Non-square textures get a doubled effective height
                lh_eff   = (lw != lh) ? lh + 1 : lh;
                height   = 64'd1 << lh_eff;
                lph      = (lw >= PAGE_LOG2) ? lw - PAGE_LOG2 : 0;
                lpv      = (lh_eff >= PAGE_LOG2) ? lh_eff - PAGE_LOG2 : 0;
                page_num = ((y >> PAGE_LOG2) << lph) + (x >> PAGE_LOG2);
                page     = (page_num >> lpv) * 64'd32 * height * 64'd2
                         + (page_num & ((64'd1 << lpv) - 64'd1)) * 64'd64 * 64'd4;
                blk      = (((x & 64'h7f) & ~64'h1f) >> 1) * height
                         + ((y & 64'h7f) & ~64'hf) * 64'd2;
                col      = pos_y * height * 64'd2 + ((x + swap) & 64'h7) * 64'd4;
                byte_sel = (x >> 3) & 64'd3;
                base     = page + blk + col + byte_sel;
                loc.nibble = 1'b1;
                loc.upper  = y[1];
            end
        endcase

        // Addresses wrap modulo the store size
        loc.addr = base[TEX_ADDR_W-1:0];
        return loc;
    endfunction

endpackage

module ptu_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // tex_addr, pal_index, write_value, pixel_x, pixel_y, zero pad
    input  logic [ptu_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind
    input  logic [ptu_pkg::KIND_W-1:0]     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // color
    input  logic [ptu_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [ptu_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ptu_pkg::CFG_DATA_W-1:0] pwdata,
    output int                             errors,
    output int                             pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import ptu_pkg::*;
    import ptu_tb_pkg::*;

    logic [TEXEL_W-1:0] tex_mirror [0:(1<<TEX_ADDR_W)-1];
    logic [COLOR_W-1:0] pal_mirror [0:PAL_DEPTH-1];
    logic [COLOR_W-1:0] expected_colors [$];
    logic [MODE_W-1:0]  cur_mode;
    logic [LOG2_W-1:0]  cur_lw;
    logic [LOG2_W-1:0]  cur_lh;
    int                 err_count = 0;

    assign errors = err_count;

    // Track config, score results and predict colors, one clock edge at a time
    always @(posedge clk or negedge rst_n)
    begin : watch
        texel_loc_t         loc;
        logic [TEXEL_W-1:0] texel;
        logic [COLOR_W-1:0] want;

        if (!rst_n)
        begin
            cur_mode = MODE_RESET;
            cur_lw   = LOG2_RESET;
            cur_lh   = LOG2_RESET;
        end
        else
        begin
            // Follow register writes; unused indexes change nothing
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_MODE:        cur_mode = pwdata[MODE_W-1:0];
                    REG_LOG2_WIDTH:  cur_lw   = pwdata[LOG2_W-1:0];
                    REG_LOG2_HEIGHT: cur_lh   = pwdata[LOG2_W-1:0];
                    default:         ;
                endcase
            end

            // Compare each delivered color with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (expected_colors.size() == 0)
                begin
                    err_count++;
                    $display("%0t: color with none expected, expected none actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (m_tdata !== want)
                    begin
                        err_count++;
                        $display("%0t: color wrong, expected %h actual %h",
                                 $time, want, m_tdata);
                    end
                end
            end

            // Apply writes and predict query colors in arrival order
            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    KIND_TEX_WR:
                        tex_mirror[s_tdata[TEX_ADDR_LSB +: TEX_ADDR_W]] =
                            s_tdata[WRITE_VALUE_LSB +: TEXEL_W];
                    KIND_PAL_WR:
                        pal_mirror[s_tdata[PAL_INDEX_LSB +: PAL_INDEX_W]] =
                            s_tdata[WRITE_VALUE_LSB +: WRITE_VALUE_W];
                    KIND_QUERY:
                    begin
                        loc = texel_locate(cur_mode, cur_lw, cur_lh,
                                           s_tdata[PIXEL_X_LSB +: PIXEL_W],
                                           s_tdata[PIXEL_Y_LSB +: PIXEL_W]);
                        texel = tex_mirror[loc.addr];
                        if (loc.nibble)
                            texel = loc.upper ? {4'h0, texel[7:4]} : {4'h0, texel[3:0]};
                        expected_colors.push_back(pal_mirror[texel]);
                    end
                    default: ;
                endcase
            end
        end
        pending = expected_colors.size();
    end

endmodule

// File: tb/tb_top.sv
// Testbench top for the palettized texture unswizzle core: stimulus, handshake pacing, verdict.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ptu_pkg::*;
    import ptu_tb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 8;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // tex_addr, pal_index, write_value, pixel_x, pixel_y, zero pad
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    // kind
    logic [KIND_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // color
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int errors;
    int pending;
    int cycle_count = 0;
    bit hold_req    = 1'b0;
    bit quiet       = 1'b0;

    // Texture bytes loaded so far; a query never reads one that was not
    bit tex_written [0:(1<<TEX_ADDR_W)-1];

    logic [MODE_W-1:0] cfg_mode = MODE_RESET;
    logic [LOG2_W-1:0] cfg_lw   = LOG2_RESET;
    logic [LOG2_W-1:0] cfg_lh   = LOG2_RESET;

    always #4 clk = ~clk;

    palettized_texture_unswizzle_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ptu_checker chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .errors   (errors),
        .pending  (pending)
    );

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("palettized_texture_unswizzle_core: mismatch");
            $finish;
        end
    end

    // Pace the result side; a hold request drops ready once for a long stretch
    initial
    begin : pacer
        bit hold_taken;

        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= quiet || ($urandom_range(99) >= 18);
        end
    end

    // Offer one word, idling first now and then, and hold it until accepted
    task automatic send_word(input logic [KIND_W-1:0]        kind,
                             input logic [TEX_ADDR_W-1:0]    addr,
                             input logic [PAL_INDEX_W-1:0]   pal,
                             input logic [WRITE_VALUE_W-1:0] value,
                             input logic [PIXEL_W-1:0]       px,
                             input logic [PIXEL_W-1:0]       py);
        logic [S_TDATA_W-1:0] word;

        if (!quiet && $urandom_range(99) < 11)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        word = '0;
        word[TEX_ADDR_LSB +: TEX_ADDR_W]       = addr;
        word[PAL_INDEX_LSB +: PAL_INDEX_W]     = pal;
        word[WRITE_VALUE_LSB +: WRITE_VALUE_W] = value;
        word[PIXEL_X_LSB +: PIXEL_W]           = px;
        word[PIXEL_Y_LSB +: PIXEL_W]           = py;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= kind;
        if (kind == KIND_TEX_WR)
            tex_written[addr] = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Offer a word of the given kind with random contents
    task automatic send_random(input logic [KIND_W-1:0] kind);
        send_word(kind, TEX_ADDR_W'($urandom), PAL_INDEX_W'($urandom), $urandom,
                  PIXEL_W'($urandom), PIXEL_W'($urandom));
    endtask

    // Query a pixel, loading its texel first when that byte is still blank
    task automatic ask_pixel(input logic [PIXEL_W-1:0] px, input logic [PIXEL_W-1:0] py);
        texel_loc_t loc;

        loc = texel_locate(cfg_mode, cfg_lw, cfg_lh, px, py);
        if (!tex_written[loc.addr])
            send_word(KIND_TEX_WR, loc.addr, PAL_INDEX_W'($urandom), $urandom,
                      PIXEL_W'($urandom), PIXEL_W'($urandom));
        send_word(KIND_QUERY, TEX_ADDR_W'($urandom), PAL_INDEX_W'($urandom), $urandom,
                  px, py);
    endtask

    // Drop valid and wait until every color is back and the pipe is quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Two-phase register write; keep a copy of what the block now holds
    task automatic apb_write(input logic [REG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MODE:        cfg_mode = value[MODE_W-1:0];
            REG_LOG2_WIDTH:  cfg_lw   = value[LOG2_W-1:0];
            REG_LOG2_HEIGHT: cfg_lh   = value[LOG2_W-1:0];
            default:         ;
        endcase
    endtask

    // One random word: mostly queries, with writes and ignored kinds between
    task automatic random_word();
        int                 pick;
        logic [PIXEL_W-1:0] px;
        logic [PIXEL_W-1:0] py;

        pick = $urandom_range(99);
        px = $urandom_range(1) ? PIXEL_W'($urandom) : PIXEL_W'($urandom_range(31));
        py = $urandom_range(1) ? PIXEL_W'($urandom) : PIXEL_W'($urandom_range(31));
        if (pick < 60)
            ask_pixel(px, py);
        else if (pick < 80)
            send_random(KIND_TEX_WR);
        else if (pick < 93)
            send_random(KIND_PAL_WR);
        else
            send_random(KIND_NONE);
    endtask

    // Reconfigure while idle, hit the corner pixels, then run random words
    task automatic run_phase(input logic [MODE_W-1:0] mode,
                             input logic [LOG2_W-1:0] lw,
                             input logic [LOG2_W-1:0] lh,
                             input int                count,
                             input bit                hold_off,
                             input bit                calm);
        settle();
        apb_write(REG_MODE, ($urandom & ~32'h3) | CFG_DATA_W'(mode));
        apb_write(REG_LOG2_WIDTH, ($urandom & ~32'hf) | CFG_DATA_W'(lw));
        apb_write(REG_LOG2_HEIGHT, ($urandom & ~32'hf) | CFG_DATA_W'(lh));
        quiet = calm;
        ask_pixel('0, '0);
        ask_pixel('1, '1);
        ask_pixel('0, '1);
        ask_pixel('1, '0);
        if (hold_off)
            hold_req = 1'b1;
        repeat (count) random_word();
        quiet = 1'b0;
    endtask

    initial
    begin : stimulus
        logic [PAL_INDEX_W-1:0] idx;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every palette entry, zero and all ones at the ends
        for (int i = 0; i < PAL_DEPTH; i++)
        begin
            idx = PAL_INDEX_W'(i);
            send_word(KIND_PAL_WR, TEX_ADDR_W'($urandom), idx,
                      (i == 0) ? 32'h0 : (i == PAL_DEPTH - 1) ? 32'hffff_ffff : $urandom,
                      PIXEL_W'($urandom), PIXEL_W'($urandom));
        end

        // Directed words under the reset config
        send_word(KIND_TEX_WR, '0, '1, 32'hffff_ff00, '1, '1);
        send_word(KIND_TEX_WR, '1, '0, 32'h0000_00ff, '0, '0);
        send_word(KIND_TEX_WR, 18'h2_aaaa, 8'h55, 32'h5555_55aa, 10'h2aa, 10'h155);
        ask_pixel('0, '0);
        ask_pixel('1, '1);
        ask_pixel(10'd127, 10'd0);
        ask_pixel(10'd128, 10'd128);
        send_word(KIND_NONE, '1, '1, '1, '1, '1);
        send_word(KIND_NONE, '0, '0, '0, '0, '0);
        ask_pixel(10'd5, 10'd3);

        // Write the unused register index with everything set
        settle();
        apb_write(REG_UNUSED, 32'hffff_ffff);
        ask_pixel(10'd6, 10'd9);

        // Fixed phases over every mode and the dimension extremes
        run_phase(MODE_LIN8, 4'd7, 4'd7, 8, 1'b0, 1'b0);
        run_phase(MODE_LIN4, 4'd0, 4'd0, 8, 1'b0, 1'b0);
        run_phase(MODE_SWZ8, 4'd10, 4'd10, 25, 1'b1, 1'b0);
        run_phase(MODE_SWZ4, 4'd10, 4'd10, 8, 1'b0, 1'b0);
        run_phase(MODE_SWZ4, 4'd15, 4'd4, 8, 1'b0, 1'b0);
        run_phase(MODE_SWZ4, 4'd3, 4'd9, 30, 1'b0, 1'b1);
        run_phase(MODE_SWZ8, 4'd4, 4'd15, 8, 1'b0, 1'b0);
        run_phase(MODE_LIN4, 4'd12, 4'd11, 8, 1'b0, 1'b0);
        run_phase(MODE_LIN8, 4'd0, 4'd10, 8, 1'b0, 1'b0);

        // Random settings, mostly small textures
        repeat (4)
        begin
            run_phase(MODE_W'($urandom),
                      LOG2_W'($urandom_range(3) == 0 ? $urandom_range(15)
                                                     : $urandom_range(8)),
                      LOG2_W'($urandom_range(3) == 0 ? $urandom_range(15)
                                                     : $urandom_range(8)),
                      5, 1'b0, 1'b0);
        end

        settle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("palettized_texture_unswizzle_core: match");
        else
            $display("palettized_texture_unswizzle_core: mismatch");
        $finish;
    end

endmodule

// File: palettized_texture_unswizzle_core.f
design/ptu_pkg.sv
design/ptu_ram.sv
design/ptu_addr_gen.sv
design/ptu_out_queue.sv
design/palettized_texture_unswizzle_core.sv
tb/ptu_checker.sv
tb/tb_top.sv
